### rtl/core/aes_block_engine_macros.svh
// Assertion macros for the AES block engine checker.
`ifndef AES_BLOCK_ENGINE_MACROS_SVH
`define AES_BLOCK_ENGINE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AES_BLK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define AES_BLK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/aes_blk_pkg.sv
// Shared types, tables and GF(2^8) helpers for the AES block engine.
package aes_blk_pkg;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_KEXP  = 6'b000010,
    ST_RINIT = 6'b000100,
    ST_RADD  = 6'b001000,
    ST_ROUND = 6'b010000,
    ST_OUT   = 6'b100000
  } aes_state_e;

  typedef logic [127:0] aes_block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    logic [31:0] r;
    for (int i = 0; i < 4; i++) begin
      r[8*i +: 8] = SBOX[w[8*i +: 8]];
    end
    return r;
  endfunction

  // 2,3,1,1 column mix
  function automatic logic [31:0] mix_fwd(input logic [31:0] c);
    logic [31:0] r;
    logic [7:0]  b0, b1, b2, b3;
    for (int k = 0; k < 4; k++) begin
      b0 = c[8*k +: 8];
      b1 = c[8*((k+1)%4) +: 8];
      b2 = c[8*((k+2)%4) +: 8];
      b3 = c[8*((k+3)%4) +: 8];
      r[8*k +: 8] = xt(b0) ^ xt(b1) ^ b1 ^ b2 ^ b3;
    end
    return r;
  endfunction

  // 14,11,13,9 column mix
  function automatic logic [31:0] mix_inv(input logic [31:0] c);
    logic [31:0] r;
    logic [7:0]  b [4];
    logic [7:0]  x2 [4];
    logic [7:0]  x4 [4];
    logic [7:0]  x8 [4];
    for (int k = 0; k < 4; k++) begin
      b[k]  = c[8*k +: 8];
      x2[k] = xt(b[k]);
      x4[k] = xt(x2[k]);
      x8[k] = xt(x4[k]);
    end
    for (int k = 0; k < 4; k++) begin
      r[8*k +: 8] = (x8[k] ^ x4[k] ^ x2[k])
                  ^ (x8[(k+1)%4] ^ x2[(k+1)%4] ^ b[(k+1)%4])
                  ^ (x8[(k+2)%4] ^ x4[(k+2)%4] ^ b[(k+2)%4])
                  ^ (x8[(k+3)%4] ^ b[(k+3)%4]);
    end
    return r;
  endfunction

endpackage

### rtl/core/aes_blk_if.sv
// Stream interfaces for the AES block engine: input words and result words.
interface aes_blk_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

interface aes_blk_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic        last_word;
  modport source (output valid, output out_word, output last_word, input ready);
  modport sink   (input valid, input out_word, input last_word, output ready);
endinterface

### rtl/core/aes_blk_round.sv
// One AES round (encrypt or decrypt), shared by every round of a block.
module aes_blk_round (
  input  aes_blk_pkg::aes_block_t state_i,
  input  aes_blk_pkg::aes_block_t rkey_i,
  input  logic                    decrypt_i,
  input  logic                    final_i,
  output aes_blk_pkg::aes_block_t state_o
);
  import aes_blk_pkg::*;

  aes_block_t sh_fwd, sub_fwd, mix_f;
  aes_block_t sh_inv, sub_inv, key_inv, mix_i;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sub_fwd[8*i +: 8] = SBOX[state_i[8*i +: 8]];
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        sh_fwd[8*(r+4*c) +: 8]           = sub_fwd[8*(r+4*((c+r)%4)) +: 8];
        sh_inv[8*(r+4*((c+r)%4)) +: 8]   = state_i[8*(r+4*c) +: 8];
      end
    end
    for (int i = 0; i < 16; i++) begin
      sub_inv[8*i +: 8] = INV_SBOX[sh_inv[8*i +: 8]];
    end
    key_inv = sub_inv ^ rkey_i;
    for (int c = 0; c < 4; c++) begin
      mix_f[32*c +: 32] = mix_fwd(sh_fwd[32*c +: 32]);
      mix_i[32*c +: 32] = mix_inv(key_inv[32*c +: 32]);
    end
    if (decrypt_i) begin
      state_o = final_i ? key_inv : mix_i;
    end else begin
      state_o = (final_i ? sh_fwd : mix_f) ^ rkey_i;
    end
  end

endmodule

### rtl/core/aes_block_engine.sv
// AES-ECB engine top level: config port, word packing, key expansion, round sequencer.
//
//   Channel   Dir  Handshake              Payload
//   req_i     in   valid/ready            data_word[31:0]
//   rsp_o     out  valid/ready            out_word[31:0], last_word
//   APB       in   psel/penable/pwrite    paddr[5:0], pwdata[63:0] -> prdata[63:0]
//
// Words 1..3 of a block are held in pend_q. The fourth word starts a run of
// 4*(Nr+1) key-expansion steps (44/52/60, one key word per cycle through the
// S-box unit), two setup states and Nr rounds on the shared round unit, then
// four result words on rsp_o.
// req_i.ready is high only while idle. rsp_o stalls simply hold the result.
// Reset (rst_ni low, asynchronous) clears the control and configuration registers and the word count.
module aes_block_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  aes_blk_in_if.sink         req_i,
  aes_blk_out_if.source      rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import aes_blk_pkg::*;

  // register map, one 64-bit slot each
  localparam logic [2:0] REG_KEY0  = 3'd0;
  localparam logic [2:0] REG_KEY1  = 3'd1;
  localparam logic [2:0] REG_KEY2  = 3'd2;
  localparam logic [2:0] REG_KEY3  = 3'd3;
  localparam logic [2:0] REG_KSIZE = 3'd4;
  localparam logic [2:0] REG_DIR   = 3'd5;
  localparam logic [2:0] REG_ON    = 3'd6;

  // configuration
  logic [63:0] key_q [4];
  logic [1:0]  ksize_q;
  logic        dir_q;
  logic        on_q;

  // word packing
  logic [31:0] pend_q [3];
  logic [1:0]  wcnt_q;

  // sequencer
  aes_state_e  st_q, st_d;
  aes_block_t  blk_q;
  logic [5:0]  kidx_q;   // key word index during expansion
  logic [2:0]  kmod_q;   // kidx modulo nk
  logic [7:0]  rcon_q;
  logic [31:0] win_q [8]; // last eight key words, newest in slot 0
  logic [3:0]  rnd_q;
  logic [1:0]  oidx_q;

  // round key store: 15 rows of four words
  logic [3:0][31:0] rk_mem [15];
  logic [127:0]     rk_q;
  logic [3:0]       rd_row;

  logic [3:0]  nk, nr;
  logic [5:0]  klast;
  logic [31:0] kw, kt, kprev, kold;
  aes_block_t  rnd_out;

  logic wr_en;
  logic in_acc, out_acc;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // key size code three behaves as 256 bit
  always_comb begin
    unique case (ksize_q)
      2'd0:    begin nk = 4'd4; nr = 4'd10; klast = 6'd43; end
      2'd1:    begin nk = 4'd6; nr = 4'd12; klast = 6'd51; end
      default: begin nk = 4'd8; nr = 4'd14; klast = 6'd59; end
    endcase
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[5:3])
      REG_KEY0:  prdata = key_q[0];
      REG_KEY1:  prdata = key_q[1];
      REG_KEY2:  prdata = key_q[2];
      REG_KEY3:  prdata = key_q[3];
      REG_KSIZE: prdata = {62'd0, ksize_q};
      REG_DIR:   prdata = {63'd0, dir_q};
      REG_ON:    prdata = {63'd0, on_q};
      default:   prdata = '0;
    endcase
  end

  assign req_i.ready     = st_q == ST_IDLE;
  assign in_acc          = req_i.valid && req_i.ready;
  assign rsp_o.valid     = st_q == ST_OUT;
  assign rsp_o.out_word  = blk_q[32*oidx_q +: 32];
  assign rsp_o.last_word = oidx_q == 2'd3;
  assign out_acc         = rsp_o.valid && rsp_o.ready;

  // key expansion word
  always_comb begin
    kprev = win_q[0];
    unique case (nk)
      4'd4:    kold = win_q[3];
      4'd6:    kold = win_q[5];
      default: kold = win_q[7];
    endcase
    if (kmod_q == 3'd0) begin
      kt = sub_word({kprev[7:0], kprev[31:8]}) ^ {24'd0, rcon_q};
    end else if (nk == 4'd8 && kmod_q == 3'd4) begin
      kt = sub_word(kprev);
    end else begin
      kt = kprev;
    end
    if (kidx_q < {2'd0, nk}) begin
      kw = kidx_q[0] ? key_q[kidx_q[2:1]][63:32] : key_q[kidx_q[2:1]][31:0];
    end else begin
      kw = kold ^ kt;
    end
  end

  // row read schedule: encrypt walks up, decrypt walks down
  always_comb begin
    rd_row = '0;
    if (st_q == ST_RINIT) begin
      rd_row = dir_q ? nr : 4'd0;
    end else if (st_q == ST_RADD) begin
      rd_row = dir_q ? nr - 4'd1 : 4'd1;
    end else if (st_q == ST_ROUND && rnd_q != nr) begin
      rd_row = dir_q ? nr - 4'd1 - rnd_q : rnd_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_KEXP) begin
      rk_mem[kidx_q[5:2]][kidx_q[1:0]] <= kw;
    end
    rk_q <= rk_mem[rd_row];
  end

  aes_blk_round u_round (
    .state_i   (blk_q),
    .rkey_i    (rk_q),
    .decrypt_i (dir_q),
    .final_i   (rnd_q == nr),
    .state_o   (rnd_out)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:  if (in_acc && on_q && wcnt_q == 2'd3) st_d = ST_KEXP;
      ST_KEXP:  if (kidx_q == klast) st_d = ST_RINIT;
      ST_RINIT: st_d = ST_RADD;
      ST_RADD:  st_d = ST_ROUND;
      ST_ROUND: if (rnd_q == nr) st_d = ST_OUT;
      ST_OUT:   if (out_acc && oidx_q == 2'd3) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  // control and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      wcnt_q  <= '0;
      key_q   <= '{default: '0};
      ksize_q <= '0;
      dir_q   <= 1'b0;
      on_q    <= 1'b0;
      kidx_q  <= '0;
      kmod_q  <= '0;
      rcon_q  <= 8'h01;
      rnd_q   <= '0;
      oidx_q  <= '0;
    end else begin
      st_q <= st_d;
      if (wr_en) begin
        unique case (paddr[5:3])
          REG_KEY0:  key_q[0] <= pwdata;
          REG_KEY1:  key_q[1] <= pwdata;
          REG_KEY2:  key_q[2] <= pwdata;
          REG_KEY3:  key_q[3] <= pwdata;
          REG_KSIZE: ksize_q  <= pwdata[1:0];
          REG_DIR:   dir_q    <= pwdata[0];
          REG_ON:    on_q     <= pwdata[0];
          default:   ;
        endcase
      end
      if (wr_en && paddr[5:3] == REG_ON && !pwdata[0]) begin
        wcnt_q <= '0;
      end else if (in_acc) begin
        wcnt_q <= on_q ? wcnt_q + 2'd1 : 2'd0;
      end
      if (st_q == ST_IDLE) begin
        kidx_q <= '0;
        kmod_q <= '0;
        rcon_q <= 8'h01;
      end else if (st_q == ST_KEXP) begin
        kidx_q <= kidx_q + 6'd1;
        kmod_q <= (kmod_q == nk[2:0] - 3'd1 || (nk == 4'd8 && kmod_q == 3'd7))
                  ? 3'd0 : kmod_q + 3'd1;
        if (kidx_q >= {2'd0, nk} && kmod_q == 3'd0) rcon_q <= xt(rcon_q);
      end
      if (st_q == ST_RADD) begin
        rnd_q <= 4'd1;
      end else if (st_q == ST_ROUND) begin
        rnd_q <= rnd_q + 4'd1;
      end
      if (st_q == ST_ROUND) begin
        oidx_q <= '0;
      end else if (out_acc) begin
        oidx_q <= oidx_q + 2'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc && on_q && wcnt_q != 2'd3) pend_q[wcnt_q] <= req_i.data_word;
    if (in_acc && on_q && wcnt_q == 2'd3) begin
      blk_q <= {req_i.data_word, pend_q[2], pend_q[1], pend_q[0]};
    end else if (st_q == ST_RADD) begin
      blk_q <= blk_q ^ rk_q;
    end else if (st_q == ST_ROUND) begin
      blk_q <= rnd_out;
    end
    if (st_q == ST_KEXP) begin
      win_q[0] <= kw;
      for (int k = 1; k < 8; k++) win_q[k] <= win_q[k-1];
    end
  end

endmodule

### rtl/core/aes_blk_chk.sv
// Port-level checker for the AES block engine, bound to the top level.
`include "aes_block_engine_macros.svh"

module aes_blk_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] rsp_word_i,
  input logic        rsp_last_i
);

  // never takes a word while a result is on offer
  `AES_BLK_ASSERT_NOW(a_no_overlap, rsp_valid_i, !req_ready_i, "input ready during result")
  // a stalled result holds
  `AES_BLK_ASSERT_NEXT(a_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_word_i) && $stable(rsp_last_i), "stalled result changed")
  // after the last word the engine is idle again
  `AES_BLK_ASSERT_NEXT(a_back_idle, rsp_valid_i && rsp_ready_i && rsp_last_i, req_ready_i && !rsp_valid_i, "not idle after block")
  // a non-last taken word is followed by another result word
  `AES_BLK_ASSERT_NEXT(a_burst, rsp_valid_i && rsp_ready_i && !rsp_last_i, rsp_valid_i, "result burst broken")

endmodule

bind aes_block_engine aes_blk_chk u_aes_blk_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_word_i  (rsp_o.out_word),
  .rsp_last_i  (rsp_o.last_word)
);
